### rtl/quaternion_alu_assert.svh
// Assertion macros used by the quaternion ALU top level.
`ifndef QUATERNION_ALU_ASSERT_SVH
`define QUATERNION_ALU_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define QALU_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define QALU_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/qalu_pkg.sv
// Types, constants and helper functions of the quaternion ALU.
`default_nettype none
package qalu_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int QDEPTH       = 4;
  localparam int QPTR_BITS    = $clog2(QDEPTH);
  localparam int QCNT_BITS    = $clog2(QDEPTH + 1);
  localparam int PROD_TERMS   = 16;
  localparam int CORDIC_STEPS = 18;
  localparam int CORDIC_SH    = 14;
  localparam int MOD_STEPS    = 6;

  localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;
  localparam logic [63:0]        ROUND_HALF = 64'd8192;
  localparam logic [31:0]        DEG90      = 32'd11796480;
  localparam logic [31:0]        DEG180     = 32'd23592960;
  localparam logic [31:0]        DEG270     = 32'd35389440;
  localparam logic [31:0]        DEG360     = 32'd47185920;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [3:0] mode;
    word_t      a_s;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      b_s;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
  } in_req_t;

  typedef struct packed {
    word_t      r_s;
    word_t      r_x;
    word_t      r_y;
    word_t      r_z;
    logic [1:0] status;
  } out_res_t;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_PROD  = 4'd2,
    OP_SCALE = 4'd3,
    OP_NORM  = 4'd4,
    OP_NRMZ  = 4'd5,
    OP_CONJ  = 4'd6,
    OP_INV   = 4'd7,
    OP_AXIS  = 4'd8,
    OP_NONE  = 4'd15
  } op_t;

  typedef struct packed {
    op_t     op;
    in_req_t req;
  } q_entry_t;

  typedef struct packed {
    word_t val;
    logic  ovf;
  } sat_t;

  typedef struct packed {
    logic       neg;
    logic [1:0] ai;
    logic [1:0] bi;
  } pterm_t;

  // Clamp a wide signed value to the word range.
  function automatic sat_t sat_word(input logic signed [65:0] v);
    sat_t r;
    if (v > 66'(WORD_MAX)) begin
      r.val = WORD_MAX;
      r.ovf = 1'b1;
    end else if (v < 66'(WORD_MIN)) begin
      r.val = WORD_MIN;
      r.ovf = 1'b1;
    end else begin
      r.val = v[WORD_BITS-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // Build a signed word from sign and magnitude, clamping the magnitude.
  function automatic sat_t from_mag(input logic neg, input logic [63:0] m);
    sat_t        r;
    logic [63:0] lim;
    logic [63:0] mm;
    lim   = {{(65-WORD_BITS){1'b0}}, {(WORD_BITS-1){1'b1}}} + 64'(neg);
    r.ovf = (m > lim);
    mm    = r.ovf ? lim : m;
    r.val = neg ? -mm[WORD_BITS-1:0] : mm[WORD_BITS-1:0];
    return r;
  endfunction

  function automatic logic [WORD_BITS:0] mag_word(input word_t v);
    logic [WORD_BITS:0] t;
    t = {v[WORD_BITS-1], v};
    return v[WORD_BITS-1] ? -t : t;
  endfunction

  // Hamilton product terms in accumulation order, four per result field.
  function automatic pterm_t pterm(input logic [3:0] i);
    pterm_t p;
    case (i)
      4'd0:    p = '{1'b0, 2'd0, 2'd0};
      4'd1:    p = '{1'b1, 2'd1, 2'd1};
      4'd2:    p = '{1'b1, 2'd2, 2'd2};
      4'd3:    p = '{1'b1, 2'd3, 2'd3};
      4'd4:    p = '{1'b0, 2'd0, 2'd1};
      4'd5:    p = '{1'b0, 2'd1, 2'd0};
      4'd6:    p = '{1'b0, 2'd2, 2'd3};
      4'd7:    p = '{1'b1, 2'd3, 2'd2};
      4'd8:    p = '{1'b0, 2'd0, 2'd2};
      4'd9:    p = '{1'b0, 2'd2, 2'd0};
      4'd10:   p = '{1'b0, 2'd3, 2'd1};
      4'd11:   p = '{1'b1, 2'd1, 2'd3};
      4'd12:   p = '{1'b0, 2'd0, 2'd3};
      4'd13:   p = '{1'b0, 2'd3, 2'd0};
      4'd14:   p = '{1'b0, 2'd1, 2'd2};
      default: p = '{1'b1, 2'd2, 2'd1};
    endcase
    return p;
  endfunction

  // Arctangent of 2^-i in degrees, Q17.
  function automatic logic [23:0] atan_deg(input logic [4:0] i);
    logic [23:0] a;
    case (i)
      5'd0:    a = 24'd5898240;
      5'd1:    a = 24'd3481934;
      5'd2:    a = 24'd1839759;
      5'd3:    a = 24'd933890;
      5'd4:    a = 24'd468757;
      5'd5:    a = 24'd234607;
      5'd6:    a = 24'd117332;
      5'd7:    a = 24'd58670;
      5'd8:    a = 24'd29335;
      5'd9:    a = 24'd14668;
      5'd10:   a = 24'd7334;
      5'd11:   a = 24'd3667;
      5'd12:   a = 24'd1833;
      5'd13:   a = 24'd917;
      5'd14:   a = 24'd458;
      5'd15:   a = 24'd229;
      5'd16:   a = 24'd115;
      5'd17:   a = 24'd57;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

### rtl/quaternion_alu.sv
// Top level of the quaternion ALU: request queue front end and execution back end.
//
//   channel   ports                     direction  handshake
//   request   start, busy, in_data      in         taken when start is high and busy low
//   result    out_strobe, out_data      out        one cycle per result, never held off
//
// A four-entry queue lets the front end keep taking requests; busy is high only when full.
// Add, subtract, conjugate and unused modes use the ALU state, the rest the shared multiplier.
// Norm, normalize and axis-angle run the 33-step square root, and normalize, inverse and
// axis-angle the 64-step divider, skipped at a zero root and, for inverse, at a zero or
// too large sum of squares. out_strobe rises in the cycle after the result state.
// Reset (rst_n low at a clock edge) empties the queue; the receiver cannot stall.
`default_nettype none
module quaternion_alu (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire qalu_pkg::in_req_t  in_data,
  output logic                    out_strobe,
  output qalu_pkg::out_res_t      out_data
);
  import qalu_pkg::*;

`include "quaternion_alu_assert.svh"

  // Queue head travels to the back end together with its decoded operation.
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_head;

  // Result properties checked by the assertions below.
  logic     res_all_zero;
  logic     status_known;

  qalu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  // The back end runs one request at a time and returns to idle after
  // presenting its result.
  qalu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  assign res_all_zero = (out_data.r_s == '0) && (out_data.r_x == '0) &&
                        (out_data.r_y == '0) && (out_data.r_z == '0);
  assign status_known = (out_data.status == STAT_OK) || (out_data.status == STAT_ZERO) ||
                        (out_data.status == STAT_SAT);

  // The sequencer passes through idle between results, so strobes never abut.
  `QALU_ASSERT_NXT(a_strobe_gap, out_strobe, !out_strobe, "results in adjacent cycles")
  // A zero-norm inverse returns an all-zero quaternion.
  `QALU_ASSERT_IMP(a_zero_fields, out_strobe && out_data.status == STAT_ZERO, res_all_zero, "zero-norm result not cleared")
  // Only defined status codes leave the block.
  `QALU_ASSERT_IMP(a_status_code, out_strobe, status_known, "undefined status code")
  // The queue can only fill by taking a request.
  `QALU_ASSERT_IMP(a_busy_cause, $rose(busy), $past(start), "queue filled without a request")

endmodule
`default_nettype wire

### rtl/qalu_front.sv
// Request intake: mode decode and the queue that feeds the execution sequencer.
`default_nettype none
module qalu_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire qalu_pkg::in_req_t  in_data,
  output logic                    q_valid,
  output qalu_pkg::q_entry_t      q_head,
  input  wire logic               q_pop
);
  import qalu_pkg::*;

  q_entry_t             q_mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 push;
  op_t                  op_dec;

  always_comb begin
    case (in_data.mode) inside
      OP_ADD, OP_SUB, OP_PROD, OP_SCALE, OP_NORM,
      OP_NRMZ, OP_CONJ, OP_INV, OP_AXIS: op_dec = op_t'(in_data.mode);
      default:                           op_dec = OP_NONE;
    endcase
  end

  assign busy    = (cnt_r == QCNT_BITS'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_head  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_BITS'(push) - QCNT_BITS'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{op: op_dec, req: in_data};
    end
  end

endmodule
`default_nettype wire

### rtl/qalu_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module qalu_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [64:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  import qalu_pkg::*;

  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [64:0] dvs_r, dvs_nxt;
  logic [63:0] q_r, q_nxt;
  logic [65:0] trial;

  assign trial    = {rem_r, q_r[63]};
  assign done     = done_r;
  assign quotient = q_r;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = 6'd63;
      rem_nxt = '0;
      dvs_nxt = divisor;
      q_nxt   = dividend;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 65'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[64:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

endmodule
`default_nettype wire

### rtl/qalu_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none
module qalu_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [64:0] radicand,
  output logic             done,
  output logic [32:0]      root
);
  import qalu_pkg::*;

  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [65:0] rad_r, rad_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [32:0] root_r, root_nxt;
  logic [36:0] rem_s;
  logic [36:0] trial;

  assign rem_s = {rem_r, rad_r[65:64]};
  assign trial = {2'b00, root_r, 2'b01};
  assign done  = done_r;
  assign root  = root_r;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = 6'd32;
      rad_nxt  = {1'b0, radicand};
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (run_r) begin
      rad_nxt = {rad_r[63:0], 2'b00};
      if (rem_s >= trial) begin
        rem_nxt  = 35'(rem_s - trial);
        root_nxt = {root_r[31:0], 1'b1};
      end else begin
        rem_nxt  = rem_s[34:0];
        root_nxt = {root_r[31:0], 1'b0};
      end
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

endmodule
`default_nettype wire

### rtl/qalu_back.sv
// Execution sequencer: shared multiplier, CORDIC, square root and divider.
`default_nettype none
module qalu_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire qalu_pkg::q_entry_t  q_head,
  output logic                     q_pop,
  output logic                     out_strobe,
  output qalu_pkg::out_res_t       out_data
);
  import qalu_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_ALU    = 10'b0000000010,
    ST_MUL    = 10'b0000000100,
    ST_ACC    = 10'b0000001000,
    ST_MOD    = 10'b0000010000,
    ST_CORD   = 10'b0000100000,
    ST_SQRT   = 10'b0001000000,
    ST_DSTART = 10'b0010000000,
    ST_DIV    = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_t;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  word_t                a_r [4];
  word_t                a_nxt [4];
  word_t                b_r [4];
  word_t                b_nxt [4];
  word_t                res_r [4];
  word_t                res_nxt [4];
  logic [4:0]           idx_r, idx_nxt;
  logic                 ph_r, ph_nxt;
  logic                 sat_r, sat_nxt;
  logic                 zero_r, zero_nxt;
  logic                 flip_r, flip_nxt;
  logic signed [49:0]   acc_r, acc_nxt;
  logic [64:0]          sum_r, sum_nxt;
  logic [32:0]          root_r, root_nxt;
  logic signed [65:0]   prod_r, prod_nxt;
  logic [31:0]          ang_r, ang_nxt;
  logic signed [33:0]   cx_r, cx_nxt;
  logic signed [33:0]   cy_r, cy_nxt;
  logic signed [25:0]   cz_r, cz_nxt;
  logic                 strobe_r, strobe_nxt;
  out_res_t             ores_r, ores_nxt;

  pterm_t               pt;
  logic [1:0]           a_idx;
  word_t                a_cur;
  logic [WORD_BITS:0]   a_mag;
  logic [33:0]          cy_mag;
  logic signed [32:0]   mul_x, mul_y;
  logic signed [65:0]   mul_p;
  logic signed [65:0]   prod_sh;
  logic signed [49:0]   prod_q;
  logic signed [49:0]   acc_sum;
  logic [64:0]          sum_n;
  sat_t                 fm;
  logic [31:0]          thr, u_n, z0;
  logic signed [26:0]   zf;
  logic signed [33:0]   dx, dy, xn, yn;
  logic signed [25:0]   at, zn;
  logic [33:0]          xm;
  logic                 sq_start, dv_start, sq_done, dv_done;
  logic [32:0]          sq_root;
  logic [63:0]          dv_dividend, dv_quot;
  logic [64:0]          dv_divisor;

  qalu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_n),
    .done     (sq_done),
    .root     (sq_root)
  );

  qalu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .done     (dv_done),
    .quotient (dv_quot)
  );

  assign pt      = pterm(idx_r[3:0]);
  assign a_idx   = (op_r == OP_PROD) ? pt.ai : idx_r[1:0];
  assign a_cur   = a_r[a_idx];
  assign a_mag   = mag_word(a_cur);
  assign cy_mag  = cy_r[33] ? 34'(-cy_r) : 34'(cy_r);
  assign mul_p   = mul_x * mul_y;
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign prod_q  = prod_sh[49:0];
  assign sum_n   = sum_r + 65'(prod_r[62:0]);

  // Multiplier operand selection.
  always_comb begin
    if (op_r == OP_PROD) begin
      mul_x = 33'(a_cur);
      mul_y = 33'(b_r[pt.bi]);
    end else if (op_r == OP_SCALE) begin
      mul_x = 33'(a_cur);
      mul_y = 33'(b_r[0]);
    end else if (op_r == OP_AXIS && ph_r) begin
      mul_x = a_mag;
      mul_y = cy_mag[32:0];
    end else begin
      mul_x = a_mag;
      mul_y = a_mag;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    res_nxt     = res_r;
    idx_nxt     = idx_r;
    ph_nxt      = ph_r;
    sat_nxt     = sat_r;
    zero_nxt    = zero_r;
    flip_nxt    = flip_r;
    acc_nxt     = acc_r;
    sum_nxt     = sum_r;
    root_nxt    = root_r;
    prod_nxt    = prod_r;
    ang_nxt     = ang_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    cz_nxt      = cz_r;
    strobe_nxt  = 1'b0;
    ores_nxt    = ores_r;
    q_pop       = 1'b0;
    sq_start    = 1'b0;
    dv_start    = 1'b0;
    dv_dividend = '0;
    dv_divisor  = '0;
    fm          = '0;
    acc_sum     = '0;
    thr         = '0;
    u_n         = '0;
    z0          = '0;
    zf          = '0;
    dx          = '0;
    dy          = '0;
    xn          = '0;
    yn          = '0;
    at          = '0;
    zn          = '0;
    xm          = '0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          op_nxt   = q_head.op;
          a_nxt[0] = q_head.req.a_s;
          a_nxt[1] = q_head.req.a_x;
          a_nxt[2] = q_head.req.a_y;
          a_nxt[3] = q_head.req.a_z;
          b_nxt[0] = q_head.req.b_s;
          b_nxt[1] = q_head.req.b_x;
          b_nxt[2] = q_head.req.b_y;
          b_nxt[3] = q_head.req.b_z;
          for (int i = 0; i < 4; i++) begin
            res_nxt[i] = '0;
          end
          idx_nxt  = '0;
          ph_nxt   = 1'b0;
          sat_nxt  = 1'b0;
          zero_nxt = 1'b0;
          flip_nxt = 1'b0;
          acc_nxt  = '0;
          sum_nxt  = '0;
          ang_nxt  = q_head.req.a_s[WORD_BITS-1] ? 32'(-q_head.req.a_s)
                                                 : 32'(q_head.req.a_s);
          case (q_head.op) inside
            OP_ADD, OP_SUB, OP_CONJ, OP_NONE: state_nxt = ST_ALU;
            OP_AXIS: begin
              idx_nxt   = 5'(MOD_STEPS - 1);
              state_nxt = ST_MOD;
            end
            default: state_nxt = ST_MUL;
          endcase
        end
      end

      ST_ALU: begin
        for (int i = 0; i < 4; i++) begin
          case (op_r)
            OP_ADD:  fm = sat_word(66'(a_r[i]) + 66'(b_r[i]));
            OP_SUB:  fm = sat_word(66'(a_r[i]) - 66'(b_r[i]));
            OP_CONJ: fm = (i == 0) ? sat_word(66'(a_r[i])) : sat_word(-66'(a_r[i]));
            default: fm = '0;
          endcase
          res_nxt[i] = fm.val;
          sat_nxt    = sat_nxt | fm.ovf;
        end
        state_nxt = ST_OUT;
      end

      ST_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = ST_ACC;
      end

      ST_ACC: begin
        if (op_r == OP_PROD) begin
          acc_sum = pt.neg ? acc_r - prod_q : acc_r + prod_q;
          if (idx_r[1:0] == 2'd3) begin
            fm                   = sat_word(66'(acc_sum));
            res_nxt[idx_r[3:2]]  = fm.val;
            sat_nxt              = sat_r | fm.ovf;
            acc_nxt              = '0;
          end else begin
            acc_nxt = acc_sum;
          end
          if (idx_r == 5'(PROD_TERMS - 1)) begin
            state_nxt = ST_OUT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_MUL;
          end
        end else if (op_r == OP_SCALE) begin
          fm                  = sat_word(prod_sh);
          res_nxt[idx_r[1:0]] = fm.val;
          sat_nxt             = sat_r | fm.ovf;
          if (idx_r == 5'd3) begin
            state_nxt = ST_OUT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_MUL;
          end
        end else if (op_r == OP_AXIS && ph_r) begin
          state_nxt = ST_DSTART;
        end else begin
          // Sum of squared magnitudes.
          sum_nxt = sum_n;
          if (idx_r != 5'd3) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_MUL;
          end else if (op_r == OP_INV) begin
            idx_nxt = '0;
            if (sum_n == '0) begin
              zero_nxt  = 1'b1;
              state_nxt = ST_OUT;
            end else if (sum_n[64]) begin
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_DSTART;
            end
          end else begin
            sq_start  = 1'b1;
            state_nxt = ST_SQRT;
          end
        end
      end

      ST_SQRT: begin
        if (sq_done) begin
          root_nxt = sq_root;
          if (op_r == OP_NORM) begin
            fm         = from_mag(1'b0, 64'(sq_root));
            res_nxt[0] = fm.val;
            sat_nxt    = sat_r | fm.ovf;
            state_nxt  = ST_OUT;
          end else if (op_r == OP_NRMZ) begin
            if (sq_root == '0) begin
              res_nxt   = a_r;
              state_nxt = ST_OUT;
            end else begin
              idx_nxt   = '0;
              state_nxt = ST_DSTART;
            end
          end else begin
            if (sq_root == '0) begin
              state_nxt = ST_OUT;
            end else begin
              ph_nxt    = 1'b1;
              idx_nxt   = 5'd1;
              state_nxt = ST_MUL;
            end
          end
        end
      end

      ST_DSTART: begin
        dv_start = 1'b1;
        case (op_r)
          OP_INV: begin
            dv_dividend = 64'(a_mag) << (2 * FRAC_BITS);
            dv_divisor  = sum_r;
          end
          OP_NRMZ: begin
            dv_dividend = 64'(a_mag) << FRAC_BITS;
            dv_divisor  = 65'(root_r);
          end
          default: begin
            dv_dividend = prod_r[63:0];
            dv_divisor  = 65'(root_r);
          end
        endcase
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        if (dv_done) begin
          case (op_r)
            OP_INV: begin
              if (idx_r == '0) begin
                fm = from_mag(a_cur[WORD_BITS-1], dv_quot);
              end else begin
                fm = from_mag(!a_cur[WORD_BITS-1] && (a_cur != '0), dv_quot);
              end
            end
            OP_NRMZ: fm = from_mag(a_cur[WORD_BITS-1], dv_quot);
            default: fm = from_mag(a_cur[WORD_BITS-1] != cy_r[33],
                                   (dv_quot + ROUND_HALF) >> CORDIC_SH);
          endcase
          res_nxt[idx_r[1:0]] = fm.val;
          sat_nxt             = sat_r | fm.ovf;
          idx_nxt             = idx_r + 1'b1;
          if (idx_r == 5'd3) begin
            state_nxt = ST_OUT;
          end else if (op_r == OP_AXIS) begin
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_DSTART;
          end
        end
      end

      ST_MOD: begin
        // Angle magnitude modulo 360 degrees by shifted compare and subtract.
        thr     = DEG360 << idx_r[2:0];
        u_n     = (ang_r >= thr) ? ang_r - thr : ang_r;
        ang_nxt = u_n;
        if (idx_r == '0) begin
          z0 = (a_r[0][WORD_BITS-1] && u_n != '0) ? DEG360 - u_n : u_n;
          zf = {1'b0, z0[25:0]};
          if (z0 > DEG90) begin
            if (z0 < DEG270) begin
              zf       = zf - 27'(DEG180);
              flip_nxt = 1'b1;
            end else begin
              zf = zf - 27'(DEG360);
            end
          end
          cz_nxt    = zf[25:0];
          cx_nxt    = CORDIC_K;
          cy_nxt    = '0;
          state_nxt = ST_CORD;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end

      ST_CORD: begin
        dx = cy_r >>> idx_r;
        dy = cx_r >>> idx_r;
        at = 26'(atan_deg(idx_r));
        if (!cz_r[25]) begin
          xn = cx_r - dx;
          yn = cy_r + dy;
          zn = cz_r - at;
        end else begin
          xn = cx_r + dx;
          yn = cy_r - dy;
          zn = cz_r + at;
        end
        cz_nxt = zn;
        if (idx_r == 5'(CORDIC_STEPS - 1)) begin
          if (flip_r) begin
            xn = -xn;
            yn = -yn;
          end
          xm         = xn[33] ? 34'(-xn) : 34'(xn);
          fm         = from_mag(xn[33], (64'(xm) + ROUND_HALF) >> CORDIC_SH);
          res_nxt[0] = fm.val;
          sat_nxt    = sat_r | fm.ovf;
          sum_nxt    = '0;
          ph_nxt     = 1'b0;
          idx_nxt    = 5'd1;
          state_nxt  = ST_MUL;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
        cx_nxt = xn;
        cy_nxt = yn;
      end

      ST_OUT: begin
        strobe_nxt      = 1'b1;
        ores_nxt.r_s    = res_r[0];
        ores_nxt.r_x    = res_r[1];
        ores_nxt.r_y    = res_r[2];
        ores_nxt.r_z    = res_r[3];
        ores_nxt.status = sat_r ? STAT_SAT : (zero_r ? STAT_ZERO : STAT_OK);
        state_nxt       = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_strobe = strobe_r;
  assign out_data   = ores_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    res_r  <= res_nxt;
    idx_r  <= idx_nxt;
    ph_r   <= ph_nxt;
    sat_r  <= sat_nxt;
    zero_r <= zero_nxt;
    flip_r <= flip_nxt;
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
    root_r <= root_nxt;
    prod_r <= prod_nxt;
    ang_r  <= ang_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    ores_r <= ores_nxt;
  end

endmodule
`default_nettype wire
